[sv/ttbd_pkg.sv]
// ----------------------------------------------------------------------------
// ttbd_pkg
// Shared types and constants for the tap tempo BPM detector.
// ----------------------------------------------------------------------------
package ttbd_pkg;

  // tap history
  localparam int unsigned HIST_DEPTH = 4;
  localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int unsigned IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned BPM_W   = 16;
  localparam int unsigned BLINK_W = 10;
  localparam int unsigned TAPS_W  = 5;

  // divider: numerator is at most 960000 * (HIST_DEPTH - 1), which fits 24 bits
  localparam int unsigned DIV_W = 24;
  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] BEAT_Q4 = 24'd960000;

  // stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BPM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK       = 3'd4;

  localparam logic [15:0]        RST_TIMEOUT     = 16'd2000;
  localparam logic [BPM_W-1:0]   RST_MIN_BPM     = 16'd640;
  localparam logic [BPM_W-1:0]   RST_MAX_BPM     = 16'd4800;
  localparam logic [BPM_W-1:0]   RST_DEFAULT_BPM = 16'd1920;
  localparam logic [BLINK_W-1:0] RST_BLINK       = 10'd50;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_BPM_GO,
    S_BPM_WAIT,
    S_INT_GO,
    S_INT_WAIT,
    S_BLINK,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic step;
    logic bpm_go;
    logic bpm_latch;
    logic int_go;
    logic int_latch;
    logic blink;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic need_bpm;
    logic div_done;
  } status_t;

endpackage

[sv/ttbd_div.sv]
// ----------------------------------------------------------------------------
// ttbd_div
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per division.
// ----------------------------------------------------------------------------
module ttbd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ttbd_pkg::DIV_W-1:0]        dividend_i,
  input  logic [ttbd_pkg::TIME_W-1:0]       divisor_i,
  output logic                              done_o,
  output logic [ttbd_pkg::DIV_W-1:0]        quotient_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [ttbd_pkg::CNT_W-1:0]    cnt_q;
  logic [ttbd_pkg::TIME_W-1:0]   rem_q;
  logic [ttbd_pkg::TIME_W-1:0]   dvs_q;
  logic [ttbd_pkg::DIV_W-1:0]    quo_q;
  logic [ttbd_pkg::TIME_W:0]     trial;
  logic [ttbd_pkg::TIME_W:0]     diff;
  logic                          take;

  assign trial = {rem_q, quo_q[ttbd_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ttbd_pkg::CNT_W'(ttbd_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[ttbd_pkg::TIME_W-1:0] : trial[ttbd_pkg::TIME_W-1:0];
      quo_q <= {quo_q[ttbd_pkg::DIV_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

[sv/ttbd_dpath.sv]
// ----------------------------------------------------------------------------
// ttbd_dpath
// Datapath: time counter, tap history, tempo and beat interval, LED timing,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module ttbd_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttbd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttbd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                action_i,
  input  logic                                button_i,
  input  ttbd_pkg::cmd_t                      cmd_i,
  output ttbd_pkg::status_t                   status_o,
  output logic [ttbd_pkg::OUT_DATA_W-1:0]     out_data_o
);

  // configuration
  logic [15:0]                    timeout_q;
  logic [ttbd_pkg::BPM_W-1:0]     min_bpm_q;
  logic [ttbd_pkg::BPM_W-1:0]     max_bpm_q;
  logic [ttbd_pkg::BPM_W-1:0]     dflt_bpm_q;
  logic [ttbd_pkg::BLINK_W-1:0]   blink_q;

  // state
  logic [ttbd_pkg::TIME_W-1:0]    time_q;
  logic                           btn_prev_q;
  logic                           tap_q;
  logic                           clear_q;
  logic [ttbd_pkg::TIME_W-1:0]    hist_q [ttbd_pkg::HIST_DEPTH];
  logic [ttbd_pkg::FILL_W-1:0]    fill_q;
  logic [ttbd_pkg::TIME_W-1:0]    last_tap_q;
  logic [ttbd_pkg::BPM_W-1:0]     bpm_q;
  logic                           known_q;
  logic                           led_q;
  logic [ttbd_pkg::TIME_W-1:0]    led_since_q;
  logic [ttbd_pkg::TIME_W-1:0]    last_beat_q;
  logic [ttbd_pkg::TIME_W-1:0]    interval_q;
  logic                           span_zero_q;
  logic [ttbd_pkg::OUT_DATA_W-1:0] out_q;

  // tap step
  logic                           gap;
  logic [ttbd_pkg::FILL_W-1:0]    fill_base;
  logic                           full;
  logic [ttbd_pkg::FILL_W-1:0]    fill_next;

  // divider
  logic [ttbd_pkg::TIME_W-1:0]    span;
  logic [ttbd_pkg::DIV_W-1:0]     taps_m1;
  logic [ttbd_pkg::DIV_W-1:0]     numer;
  logic                           div_start;
  logic [ttbd_pkg::DIV_W-1:0]     div_dividend;
  logic [ttbd_pkg::TIME_W-1:0]    div_divisor;
  logic                           div_done;
  logic [ttbd_pkg::DIV_W-1:0]     quotient;
  logic [ttbd_pkg::DIV_W-1:0]     q_low;
  logic [ttbd_pkg::BPM_W-1:0]     bpm_clamped;

  // blink
  logic                           lit_off;
  logic                           lit_keep;
  logic                           fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= ttbd_pkg::RST_TIMEOUT;
      min_bpm_q  <= ttbd_pkg::RST_MIN_BPM;
      max_bpm_q  <= ttbd_pkg::RST_MAX_BPM;
      dflt_bpm_q <= ttbd_pkg::RST_DEFAULT_BPM;
      blink_q    <= ttbd_pkg::RST_BLINK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttbd_pkg::CFG_TIMEOUT:     timeout_q  <= cfg_data_i;
        ttbd_pkg::CFG_MIN_BPM:     min_bpm_q  <= cfg_data_i;
        ttbd_pkg::CFG_MAX_BPM:     max_bpm_q  <= cfg_data_i;
        ttbd_pkg::CFG_DEFAULT_BPM: dflt_bpm_q <= cfg_data_i;
        ttbd_pkg::CFG_BLINK:       blink_q    <= cfg_data_i[ttbd_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // a gap longer than the timeout restarts the history
  assign gap       = (fill_q != '0) && ((time_q - last_tap_q) > {16'b0, timeout_q});
  assign fill_base = gap ? '0 : fill_q;
  assign full      = (fill_base == ttbd_pkg::FILL_W'(ttbd_pkg::HIST_DEPTH));
  assign fill_next = full ? fill_base : fill_base + 1'b1;

  assign status_o.is_clear = clear_q;
  assign status_o.need_bpm = tap_q && !clear_q && (fill_next >= ttbd_pkg::FILL_W'(2));
  assign status_o.div_done = div_done;

  // newest entry is always now, so span only needs the oldest
  assign span         = time_q - hist_q[0];
  assign taps_m1      = ttbd_pkg::DIV_W'(fill_q) - 1'b1;
  assign numer        = ttbd_pkg::BEAT_Q4 * taps_m1;
  assign div_start    = cmd_i.bpm_go || cmd_i.int_go;
  assign div_dividend = cmd_i.bpm_go ? numer : ttbd_pkg::BEAT_Q4;
  assign div_divisor  = cmd_i.bpm_go ? span : {16'b0, bpm_q};

  ttbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // raise to minimum, then lower to maximum; maximum wins on conflict
  assign q_low = (quotient < {8'b0, min_bpm_q}) ? {8'b0, min_bpm_q} : quotient;
  always_comb begin
    if (span_zero_q || (q_low > {8'b0, max_bpm_q})) begin
      bpm_clamped = max_bpm_q;
    end else begin
      bpm_clamped = q_low[ttbd_pkg::BPM_W-1:0];
    end
  end

  assign lit_off  = led_q && ((time_q - led_since_q) >= {22'b0, blink_q});
  assign lit_keep = led_q && !lit_off;
  assign fire     = !lit_keep &&
                    ((last_beat_q == '0) || ((time_q - last_beat_q) >= interval_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      btn_prev_q  <= 1'b0;
      tap_q       <= 1'b0;
      clear_q     <= 1'b0;
      fill_q      <= '0;
      last_tap_q  <= '0;
      bpm_q       <= ttbd_pkg::RST_DEFAULT_BPM;
      known_q     <= 1'b0;
      led_q       <= 1'b0;
      led_since_q <= '0;
      last_beat_q <= '0;
    end else begin
      if (cmd_i.load_in) begin
        clear_q <= action_i;
        tap_q   <= !action_i && button_i && !btn_prev_q;
        if (!action_i) begin
          time_q     <= time_q + 1'b1;
          btn_prev_q <= button_i;
        end
      end
      if (cmd_i.step) begin
        if (clear_q) begin
          fill_q      <= '0;
          last_tap_q  <= '0;
          bpm_q       <= dflt_bpm_q;
          known_q     <= 1'b0;
          last_beat_q <= '0;
          led_q       <= 1'b0;
        end else if (tap_q) begin
          fill_q      <= fill_next;
          last_tap_q  <= time_q;
          led_q       <= 1'b1;
          led_since_q <= time_q;
        end
      end
      if (cmd_i.bpm_latch) begin
        bpm_q   <= bpm_clamped;
        known_q <= 1'b1;
      end
      if (cmd_i.blink && known_q) begin
        led_q <= lit_keep || fire;
        if (fire) begin
          led_since_q <= time_q;
          last_beat_q <= time_q;
        end
      end
    end
  end

  // history and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && !clear_q && tap_q) begin
      if (full) begin
        for (int i = 0; i < ttbd_pkg::HIST_DEPTH - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[ttbd_pkg::HIST_DEPTH-1] <= time_q;
      end else begin
        hist_q[fill_base[ttbd_pkg::IDX_W-1:0]] <= time_q;
      end
    end
    if (cmd_i.bpm_go) begin
      span_zero_q <= (span == '0);
    end
    if (cmd_i.int_latch) begin
      interval_q <= (bpm_q == '0) ? '1 : {8'b0, quotient};
    end
    if (cmd_i.load_out) begin
      out_q <= {ttbd_pkg::TAPS_W'(fill_q), tap_q, led_q, known_q, bpm_q};
    end
  end

  assign out_data_o = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ttbd_pkg::FILL_W'(ttbd_pkg::HIST_DEPTH))
    else $error("tap history overfilled");

  a_known_after_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bpm_latch |=> known_q)
    else $error("tempo latched but not flagged known");

endmodule

[sv/ttbd_ctrl.sv]
// ----------------------------------------------------------------------------
// ttbd_ctrl
// Controller: sequences one item through tap step, divisions, blink update
// and result hand-off; owns the stream handshakes.
// ----------------------------------------------------------------------------
module ttbd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ttbd_pkg::status_t    status_i,
  output ttbd_pkg::cmd_t       cmd_o
);

  ttbd_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;
  logic             out_free;

  assign in_acc   = in_valid_i && (state_q == ttbd_pkg::S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttbd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ttbd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ttbd_pkg::S_TAP;
        end
      end
      ttbd_pkg::S_TAP: begin
        cmd_o.step = 1'b1;
        if (status_i.is_clear) begin
          state_d = ttbd_pkg::S_OUT;
        end else if (status_i.need_bpm) begin
          state_d = ttbd_pkg::S_BPM_GO;
        end else begin
          state_d = ttbd_pkg::S_BLINK;
        end
      end
      ttbd_pkg::S_BPM_GO: begin
        cmd_o.bpm_go = 1'b1;
        state_d      = ttbd_pkg::S_BPM_WAIT;
      end
      ttbd_pkg::S_BPM_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.bpm_latch = 1'b1;
          state_d         = ttbd_pkg::S_INT_GO;
        end
      end
      ttbd_pkg::S_INT_GO: begin
        cmd_o.int_go = 1'b1;
        state_d      = ttbd_pkg::S_INT_WAIT;
      end
      ttbd_pkg::S_INT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.int_latch = 1'b1;
          state_d         = ttbd_pkg::S_BLINK;
        end
      end
      ttbd_pkg::S_BLINK: begin
        cmd_o.blink = 1'b1;
        state_d     = ttbd_pkg::S_OUT;
      end
      ttbd_pkg::S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ttbd_pkg::S_IDLE;
        end
      end
      default: state_d = ttbd_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ttbd_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_to_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ttbd_pkg::S_TAP))
    else $error("accepted beat not followed by tap step");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule

[sv/tap_tempo_bpm_detector_core.sv]
// ----------------------------------------------------------------------------
// tap_tempo_bpm_detector_core
// Tap tempo estimator: one input beat per millisecond tick or clear, one
// result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat is a millisecond tick carrying the button level (tuser 0)
// or a history clear (tuser 1); each gives exactly one result beat with the
// tempo in Q12.4 BPM, its valid flag, the LED level, a tap flag and the
// number of held taps. A plain tick runs the tap step and the blink update
// before its result is loaded, a clear only the tap step; a tap that leaves
// two or more taps in history also runs two divisions on the shared restoring
// divider (tempo, then beat interval), each with its start and latch steps.
// The input is ready again in the cycle after the result is loaded; a result
// still waiting holds the core in its last step until it is taken. One input
// beat is in flight at a time; a new beat is accepted while the previous
// result waits in the output register. Configuration writes take effect at
// once and are meant for idle periods; a new default tempo is applied at the
// next clear, and reset reloads RST_DEFAULT_BPM.
module tap_tempo_bpm_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ttbd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ttbd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [ttbd_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,   // [0] button_pressed
  input  logic                                 s_axis_tuser_i,   // action
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [15:0] bpm_q4, [16] bpm_valid, [17] led, [18] tap_seen, [23:19] taps_held
  output logic [ttbd_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  ttbd_pkg::cmd_t    cmd;
  ttbd_pkg::status_t status;

  ttbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttbd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .action_i   (s_axis_tuser_i),
    .button_i   (s_axis_tdata_i[0]),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (m_axis_tdata_o)
  );

endmodule
